// File: hdl/dht_pkg.sv
// shared types, sizes and codes for the daily history table
// no dependencies; every other file refers to it by scoped names
package dht_pkg;

  // table size and derived index / count widths
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 2);

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // stream widths
  localparam int IN_TDATA_W  = 192;
  localparam int OUT_TDATA_W = 16;

  // stored field widths
  localparam int KEY_W      = 32;
  localparam int STEPS_W    = 32;
  localparam int MINUTES_W  = 26;
  localparam int DISTANCE_W = 19;
  localparam int CAL_W      = 32;

  // reciprocal constants: x / 60 = (x * MIN_MAGIC) >> MIN_SHIFT,
  // x / 10000 = (x * DIST_MAGIC) >> DIST_SHIFT, exact for any 32-bit x
  localparam logic [31:0] MIN_MAGIC  = 32'h8888_8889;
  localparam int          MIN_SHIFT  = 37;
  localparam logic [31:0] DIST_MAGIC = 32'hD1B7_1759;
  localparam int          DIST_SHIFT = 45;

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_COUNT  = 1'b1;

  // result action codes
  localparam logic [1:0] ACT_UPDATED = 2'd0;
  localparam logic [1:0] ACT_FILLED  = 2'd1;
  localparam logic [1:0] ACT_EVICTED = 2'd2;
  localparam logic [1:0] ACT_COUNTED = 2'd3;

  // one classified item as it travels from front to back
  // key holds day_key for a record and since_time for a count
  typedef struct packed {
    logic                  cmd;
    logic [KEY_W-1:0]      key;
    logic [STEPS_W-1:0]    steps;
    logic [MINUTES_W-1:0]  minutes;
    logic [DISTANCE_W-1:0] distance;
    logic [CAL_W-1:0]      calories;
  } item_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [STEPS_W-1:0]    steps;
    logic [MINUTES_W-1:0]  minutes;
    logic [DISTANCE_W-1:0] distance;
    logic [CAL_W-1:0]      calories;
  } entry_t;

  // queue status toward both ends
  typedef struct packed {
    logic  valid;
    logic  full;
    item_t item;
  } qstat_t;

endpackage

// File: hdl/dht_front.sv
// front end: input register, unit scaling and key selection
// depends on dht_pkg
module dht_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dht_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tuser,
  input  logic                          q_full,
  output logic                          push,
  output dht_pkg::item_t                push_item
);

  // raw item as taken from the bus
  typedef struct packed {
    logic        cmd;
    logic [31:0] day_key;
    logic [31:0] since_time;
    logic [31:0] step_total;
    logic [31:0] active_seconds;
    logic [31:0] walk_cm;
    logic [31:0] calorie_total;
  } raw_t;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  raw_t        s1_r;
  logic        take;
  logic [63:0] min_prod;
  logic [63:0] dist_prod;

  assign in_tready = !s1_valid_r || !q_full;
  assign take      = in_tvalid && in_tready;
  assign push      = s1_valid_r && !q_full;

  // stage valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r.cmd            <= in_tuser;
      s1_r.day_key        <= in_tdata[31:0];
      s1_r.since_time     <= in_tdata[63:32];
      s1_r.step_total     <= in_tdata[95:64];
      s1_r.active_seconds <= in_tdata[127:96];
      s1_r.walk_cm        <= in_tdata[159:128];
      s1_r.calorie_total  <= in_tdata[191:160];
    end
  end

  // divide by 60 and by 10000 through reciprocal multiplies
  assign min_prod  = 64'(s1_r.active_seconds) * 64'(dht_pkg::MIN_MAGIC);
  assign dist_prod = 64'(s1_r.walk_cm) * 64'(dht_pkg::DIST_MAGIC);

  // classified item toward the queue
  always_comb begin
    push_item.cmd      = s1_r.cmd;
    push_item.key      = (s1_r.cmd == dht_pkg::CMD_COUNT) ? s1_r.since_time : s1_r.day_key;
    push_item.steps    = s1_r.step_total;
    push_item.minutes  = dht_pkg::MINUTES_W'(min_prod >> dht_pkg::MIN_SHIFT);
    push_item.distance = dht_pkg::DISTANCE_W'(dist_prod >> dht_pkg::DIST_SHIFT);
    push_item.calories = s1_r.calorie_total;
  end

endmodule

// File: hdl/dht_queue.sv
// short register queue between the front and back ends
// depends on dht_pkg
module dht_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dht_pkg::item_t  push_item,
  input  logic            pop,
  output dht_pkg::qstat_t stat
);

  dht_pkg::item_t                 mem_r [dht_pkg::QUEUE_DEPTH];
  logic [dht_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [dht_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [dht_pkg::QCNT_W-1:0]     cnt_r;
  logic [dht_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [dht_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [dht_pkg::QCNT_W-1:0]     cnt_nxt;

  // status toward both ends
  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == dht_pkg::QCNT_W'(dht_pkg::QUEUE_DEPTH));
  assign stat.item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dht_pkg::QPTR_W'(dht_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == dht_pkg::QPTR_W'(dht_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/dht_back.sv
// back end: record table, parallel key search, count and result register
// depends on dht_pkg
module dht_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dht_pkg::qstat_t                 stat,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dht_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int D = dht_pkg::TABLE_DEPTH;

  dht_pkg::entry_t             entry_r [D];
  dht_pkg::entry_t             new_entry;
  logic [D-1:0]                hit_key;
  logic [D-1:0]                hit_free;
  logic [D-1:0]                hit_ge;
  logic [dht_pkg::IDX_W-1:0]   key_idx;
  logic [dht_pkg::IDX_W-1:0]   free_idx;
  logic [dht_pkg::IDX_W-1:0]   wr_idx;
  logic                        wr_en;
  logic                        evict;
  logic [dht_pkg::CNT_W-1:0]   count;
  logic [1:0]                  action_nxt;
  logic [3:0]                  slot_nxt;
  logic [4:0]                  count_nxt;
  logic                        out_valid_r;
  logic [1:0]                  action_r;
  logic [3:0]                  slot_r;
  logic [4:0]                  count_r;

  assign pop = stat.valid && (!out_valid_r || out_tready);

  // parallel compare against every entry
  always_comb begin
    for (int i = 0; i < D; i++) begin
      hit_key[i]  = (entry_r[i].key == stat.item.key);
      hit_free[i] = (entry_r[i].key == '0);
      hit_ge[i]   = (entry_r[i].key >= stat.item.key);
    end
  end

  // first matching and first free slot
  always_comb begin
    key_idx  = '0;
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (hit_key[i]) begin
        key_idx = dht_pkg::IDX_W'(i);
      end
      if (hit_free[i]) begin
        free_idx = dht_pkg::IDX_W'(i);
      end
    end
  end

  assign count = dht_pkg::CNT_W'($countones(hit_ge)) + dht_pkg::CNT_W'(1);

  // classify the command: slot and action for a record, count for a count
  always_comb begin
    wr_en      = pop && (stat.item.cmd == dht_pkg::CMD_RECORD);
    evict      = 1'b0;
    wr_idx     = dht_pkg::IDX_W'(D - 1);
    action_nxt = dht_pkg::ACT_COUNTED;
    slot_nxt   = '0;
    count_nxt  = 5'(count);
    if (stat.item.cmd == dht_pkg::CMD_RECORD) begin
      count_nxt = '0;
      if (|hit_key) begin
        wr_idx     = key_idx;
        action_nxt = dht_pkg::ACT_UPDATED;
      end else if (|hit_free) begin
        wr_idx     = free_idx;
        action_nxt = dht_pkg::ACT_FILLED;
      end else begin
        evict      = wr_en;
        action_nxt = dht_pkg::ACT_EVICTED;
      end
      slot_nxt = 4'(wr_idx);
    end
  end

  assign new_entry.key      = stat.item.key;
  assign new_entry.steps    = stat.item.steps;
  assign new_entry.minutes  = stat.item.minutes;
  assign new_entry.distance = stat.item.distance;
  assign new_entry.calories = stat.item.calories;

  // table: reset to all free, write in place or shift toward the front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        entry_r[i] <= '0;
      end
    end else if (evict) begin
      for (int i = 0; i < D - 1; i++) begin
        entry_r[i] <= entry_r[i + 1];
      end
      entry_r[D - 1] <= new_entry;
    end else if (wr_en) begin
      entry_r[wr_idx] <= new_entry;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      action_r <= action_nxt;
      slot_r   <= slot_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, count_r, slot_r, action_r};

endmodule

// File: hdl/daily_history_table_top.sv
// top level of the daily history table: front, queue and back
// depends on dht_pkg, dht_front, dht_queue, dht_back
//
// channel | dir | handshake         | payload
// in_     | in  | in_tvalid/tready  | tdata 192 bits, tuser = command
// out_    | out | out_tvalid/tready | tdata 16 bits (action, slot, count)
//
// one item per cycle sustained while out_tready stays high; out_tvalid follows the accepting
// edge through the input register, a queue slot and the result register
// the back end searches all table entries combinationally and updates the table
// in the same cycle, so each item sees the table its predecessor left
// synchronous reset clears the table to all free and empties every stage
// a stalled output fills the two-entry queue, then the input register
module daily_history_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // day_key[31:0], since_time[63:32], step_total[95:64],
  // active_seconds[127:96], walk_cm[159:128], calorie_total[191:160]
  input  logic [dht_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // action[1:0], slot_written[5:2], record_count[10:6], zero[15:11]
  output logic [dht_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic            push;
  logic            pop;
  dht_pkg::item_t  push_item;
  dht_pkg::qstat_t stat;

  dht_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (stat.full),
    .push      (push),
    .push_item (push_item)
  );

  dht_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .stat      (stat)
  );

  dht_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hdl/dht_checker.sv
// port-level checks for the daily history table, bound to the top level
// depends on dht_pkg and daily_history_table_top
module dht_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dht_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a count answer names no slot
  a_count_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == dht_pkg::ACT_COUNTED |-> out_tdata[5:2] == 4'd0)
    else $error("count item carries a slot");

  // a count answer is at least one, a record answer carries no count
  a_count_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[1:0] == dht_pkg::ACT_COUNTED) == (out_tdata[10:6] != 5'd0)))
    else $error("record_count does not match action");

  // an eviction always writes the last slot
  a_evict_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == dht_pkg::ACT_EVICTED
      |-> out_tdata[5:2] == 4'(dht_pkg::TABLE_DEPTH - 1))
    else $error("eviction wrote other than the last slot");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind daily_history_table_top dht_checker u_dht_checker (.*);

// File: tb/dht_history_checker.sv
// checker for the daily history table: watches both streams, keeps its own
// copy of the table and compares every result item; depends on dht_pkg
module dht_history_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // day_key, since_time, step_total, active_seconds, walk_cm, calorie_total
  input  logic [dht_pkg::IN_TDATA_W-1:0]  in_tdata,
  // command
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // action, slot_written, record_count, zero pad
  input  logic [dht_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              expected_left
);

  localparam int DEPTH = dht_pkg::TABLE_DEPTH;

  // one expected result item
  typedef struct packed {
    logic [1:0]                action;
    logic [dht_pkg::IDX_W-1:0] slot;
    logic [dht_pkg::CNT_W-1:0] count;
  } outcome_t;

  // shadow copy of the table; minutes kept at full quotient width
  logic [31:0] day_keys     [DEPTH];
  logic [31:0] day_steps    [DEPTH];
  logic [31:0] day_minutes  [DEPTH];
  logic [18:0] day_distance [DEPTH];
  logic [31:0] day_calories [DEPTH];

  outcome_t expected_outcomes[$];
  int       fail_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // applies one item to the shadow table and returns what the block should say
  function automatic outcome_t predict_outcome(input logic cmd,
                                               input logic [dht_pkg::IN_TDATA_W-1:0] data);
    outcome_t    res;
    logic [31:0] key;
    logic [31:0] since;
    int          slot;
    int          hits;
    bit          found;
    key   = data[31:0];
    since = data[63:32];
    res   = '0;
    slot  = 0;
    hits  = 1;
    found = 1'b0;
    if (cmd == dht_pkg::CMD_COUNT) begin
      foreach (day_keys[i]) if (day_keys[i] >= since) hits++;
      res.action = dht_pkg::ACT_COUNTED;
      res.count  = hits[dht_pkg::CNT_W-1:0];
    end else begin
      // same day first; a zero key lands on the first free entry here
      for (int i = 0; i < DEPTH && !found; i++) begin
        if (day_keys[i] == key) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.action = dht_pkg::ACT_UPDATED;
      end else begin
        for (int i = 0; i < DEPTH && !found; i++) begin
          if (day_keys[i] == '0) begin
            slot  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          res.action = dht_pkg::ACT_FILLED;
        end else begin
          // full table: drop slot 0 and move everything forward
          for (int i = 0; i + 1 < DEPTH; i++) begin
            day_keys[i]     = day_keys[i+1];
            day_steps[i]    = day_steps[i+1];
            day_minutes[i]  = day_minutes[i+1];
            day_distance[i] = day_distance[i+1];
            day_calories[i] = day_calories[i+1];
          end
          slot       = DEPTH - 1;
          res.action = dht_pkg::ACT_EVICTED;
        end
      end
      day_keys[slot]     = key;
      day_steps[slot]    = data[95:64];
      day_minutes[slot]  = data[127:96] / 32'd60;
      day_distance[slot] = 19'(data[159:128] / 32'd10000);
      day_calories[slot] = data[191:160];
      res.slot           = slot[dht_pkg::IDX_W-1:0];
    end
    return res;
  endfunction

  // results are checked before new items are predicted; latency keeps them apart
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      foreach (day_keys[i]) begin
        day_keys[i]     = '0;
        day_steps[i]    = '0;
        day_minutes[i]  = '0;
        day_distance[i] = '0;
        day_calories[i] = '0;
      end
      expected_outcomes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result item", out_tdata, 0);
        end else begin
          want = expected_outcomes.pop_front();
          if (out_tdata[1:0] !== want.action)
            report_mismatch("action", out_tdata[1:0], want.action);
          if (out_tdata[5:2] !== want.slot)
            report_mismatch("slot_written", out_tdata[5:2], want.slot);
          if (out_tdata[10:6] !== want.count)
            report_mismatch("record_count", out_tdata[10:6], want.count);
          if (out_tdata[15:11] !== '0)
            report_mismatch("pad bits", out_tdata[15:11], 0);
        end
      end
      if (in_tvalid && in_tready)
        expected_outcomes.push_back(predict_outcome(in_tuser, in_tdata));
    end
    expected_left <= expected_outcomes.size();
    mismatches    <= fail_count;
  end

endmodule

// File: tb/daily_history_table_top_tb.sv
// testbench top for the daily history table: clock, reset, stimulus and verdict
// depends on dht_pkg, daily_history_table_top and dht_history_checker
module daily_history_table_top_tb;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // day_key, since_time, step_total, active_seconds, walk_cm, calorie_total
  logic [dht_pkg::IN_TDATA_W-1:0]  in_tdata;
  // command
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  // action, slot_written, record_count, zero pad
  logic [dht_pkg::OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int expected_left;

  // pacing knobs set by the stimulus and read by the sender and the receiver
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_reqs     = 0;
  logic [31:0] day_cursor;
  logic [31:0] known_days[$];

  daily_history_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dht_history_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: a hold-off with out_tready low on each new request, random stalls otherwise
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // offer one item after a random gap and hold it until accepted
  task automatic offer_item(input logic cmd, input logic [dht_pkg::IN_TDATA_W-1:0] payload);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic record_day(input logic [31:0] key, input logic [31:0] steps,
                            input logic [31:0] secs, input logic [31:0] walk,
                            input logic [31:0] cal);
    offer_item(dht_pkg::CMD_RECORD, {cal, walk, secs, steps, 32'($urandom()), key});
    if (key != '0) begin
      known_days.push_back(key);
      if (known_days.size() > 24) void'(known_days.pop_front());
    end
  endtask

  task automatic ask_count(input logic [31:0] since);
    offer_item(dht_pkg::CMD_COUNT, {32'($urandom()), 32'($urandom()), 32'($urandom()),
                                    32'($urandom()), since, 32'($urandom())});
  endtask

  // stop offering and wait until every expected result item has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  task automatic run_phase(input int items, input int idle, input int stall,
                           input bit holdoff);
    int          roll;
    logic [31:0] key;
    logic [31:0] steps;
    logic [31:0] secs;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int n = 0; n < items; n++) begin
      if (holdoff && n == items / 3) hold_reqs++;
      roll = $urandom_range(99);
      if (roll < 30) begin
        // count: thresholds around stored days, the extremes, or noise
        case ($urandom_range(5))
          0: key = '0;
          1: key = '1;
          2, 3: begin
            if (known_days.size() == 0) key = $urandom();
            else key = known_days[$urandom_range(known_days.size() - 1)]
                       + $urandom_range(2) - 1;
          end
          default: key = $urandom();
        endcase
        ask_count(key);
      end else begin
        // record: mostly revisits of recent days and the next day in order
        roll = $urandom_range(99);
        if (roll < 40 && known_days.size() != 0) begin
          key = known_days[$urandom_range(known_days.size() - 1)];
        end else if (roll < 80) begin
          day_cursor += 32'd86400;
          key = day_cursor;
        end else if (roll < 94) begin
          key = $urandom();
        end else begin
          key = '0;
        end
        steps = $urandom_range(1) ? $urandom_range(40000) : $urandom();
        secs  = $urandom_range(1) ? $urandom_range(86400) : $urandom();
        record_day(key, steps, secs, $urandom(), $urandom());
      end
    end
    drain_results();
  endtask

  // reset, directed items, random phases, verdict
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = dht_pkg::CMD_RECORD;
    in_tdata  = '0;
    day_cursor = $urandom_range(32'h7000_0000, 32'h4000_0000);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: only a zero threshold counts the free entries
    ask_count('0);
    ask_count(32'd1);
    // zero key matches the first free entry and stays free
    record_day('0, '1, '1, '1, '1);
    record_day('1, '1, '1, '1, '1);
    record_day('1, '0, '0, '0, '0);
    ask_count('1);
    // fill the rest, then overflow into eviction
    for (int i = 0; i < 15; i++) begin
      day_cursor += 32'd86400;
      record_day(day_cursor, $urandom(), $urandom(), $urandom(), $urandom());
    end
    day_cursor += 32'd86400;
    record_day(day_cursor, '1, 32'd59, 32'd9999, '0);
    // zero key on a full table evicts and leaves the last slot free
    record_day('0, $urandom(), 32'd60, 32'd10000, $urandom());
    ask_count('0);
    day_cursor += 32'd86400;
    record_day(day_cursor, $urandom(), $urandom(), $urandom(), $urandom());
    drain_results();

    run_phase(230, 0, 0, 1'b1);
    run_phase(230, 61, 0, 1'b0);
    run_phase(230, 0, 61, 1'b0);
    run_phase(230, 27, 27, 1'b1);

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
